// ===== hdl/vpvi_pkg.sv =====
`default_nettype none

package vpvi_pkg;

    // Pointer and byte widths fixed by the processor port
    localparam int PTR_W        = 14;
    localparam int BYTE_W       = 8;
    localparam int REG_SEL_W    = 3;
    localparam int REG_COUNT    = 8;
    localparam int HIGH_ADDR_W  = 6;
    localparam int FOLD_STEPS   = 4;

    localparam int VRAM_WORDS_DEF = 16384;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0]        REG_WRITE_CODE = 2'b10;
    localparam logic [BYTE_W-1:0] FRAME_BIT      = 8'h80;

    // Processor access codes
    typedef enum logic [2:0] {
        MODE_CTRL_WR = 3'd0,
        MODE_DATA_WR = 3'd1,
        MODE_DATA_RD = 3'd2,
        MODE_STAT_RD = 3'd3,
        MODE_TICK    = 3'd4
    } mode_t;

    // Work handed to the memory side
    typedef enum logic [1:0] {
        OP_CONST = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [PTR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    // Fold a pointer into a memory of the given size (size at least 1/16 of the space)
    function automatic logic [PTR_W-1:0] fold_ptr(input logic [PTR_W-1:0] ptr,
                                                  input logic [PTR_W:0] words);
        logic [PTR_W+FOLD_STEPS-1:0] rem;
        logic [PTR_W+FOLD_STEPS-1:0] div;
        rem = {{FOLD_STEPS{1'b0}}, ptr};
        for (int k = FOLD_STEPS - 1; k >= 0; k--)
        begin
            div = {{(FOLD_STEPS-1){1'b0}}, words} << k;
            if (rem >= div)
            begin
                rem = rem - div;
            end
        end
        return rem[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vpvi_ram.sv =====
`default_nettype none

module vpvi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vpvi_queue.sv =====
`default_nettype none

module vpvi_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  vpvi_pkg::cmd_t      push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output vpvi_pkg::cmd_t      pop_cmd
);

    import vpvi_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== hdl/vpvi_front.sv =====
`default_nettype none

module vpvi_front #(
    parameter int VRAM_WORDS = vpvi_pkg::VRAM_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    mode,
    input  wire logic [vpvi_pkg::BYTE_W-1:0]   bus_byte,
    input  wire logic                          mem_ready,
    input  wire logic                          q_full,
    output logic                               push,
    output vpvi_pkg::cmd_t                     push_cmd
);

    import vpvi_pkg::*;

    logic                 pending_reg, pending_next;
    logic [BYTE_W-1:0]    low_byte_reg, low_byte_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [BYTE_W-1:0]    mode_regs_reg [REG_COUNT];
    logic [BYTE_W-1:0]    mode_regs_next [REG_COUNT];
    logic                 frame_reg, frame_next;
    logic                 accept;
    logic [PTR_W-1:0]     mem_addr;
    logic [REG_SEL_W-1:0] reg_sel;

    assign in_stall = q_full || !mem_ready;
    assign accept   = in_valid && !in_stall;
    assign mem_addr = fold_ptr(ptr_reg, (PTR_W+1)'(VRAM_WORDS));
    assign reg_sel  = bus_byte[REG_SEL_W-1:0];

    // Decode the access, update port state and build the memory command
    always_comb
    begin
        pending_next   = pending_reg;
        low_byte_next  = low_byte_reg;
        ptr_next       = ptr_reg;
        mode_regs_next = mode_regs_reg;
        frame_next     = frame_reg;
        push           = accept;
        push_cmd.op    = OP_CONST;
        push_cmd.addr  = mem_addr;
        push_cmd.data  = '0;
        if (accept)
        begin
            unique case (mode)
                MODE_CTRL_WR:
                begin
                    if (!pending_reg)
                    begin
                        low_byte_next = bus_byte;
                        pending_next  = 1'b1;
                    end
                    else
                    begin
                        ptr_next = {bus_byte[HIGH_ADDR_W-1:0], low_byte_reg};
                        if (bus_byte[BYTE_W-1 -: 2] == REG_WRITE_CODE)
                        begin
                            mode_regs_next[reg_sel] = low_byte_reg;
                        end
                        pending_next = 1'b0;
                    end
                end
                MODE_DATA_WR:
                begin
                    push_cmd.op   = OP_WRITE;
                    push_cmd.data = bus_byte;
                    ptr_next      = ptr_reg + 1'b1;
                    pending_next  = 1'b0;
                end
                MODE_DATA_RD:
                begin
                    push_cmd.op  = OP_READ;
                    ptr_next     = ptr_reg + 1'b1;
                    pending_next = 1'b0;
                end
                MODE_STAT_RD:
                begin
                    push_cmd.data = frame_reg ? FRAME_BIT : '0;
                    frame_next    = 1'b0;
                    pending_next  = 1'b0;
                end
                MODE_TICK:
                begin
                    frame_next = 1'b1;
                end
                default:
                begin
                    pending_next = pending_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            low_byte_reg  <= '0;
            ptr_reg       <= '0;
            frame_reg     <= 1'b0;
            mode_regs_reg <= '{default: '0};
        end
        else
        begin
            pending_reg   <= pending_next;
            low_byte_reg  <= low_byte_next;
            ptr_reg       <= ptr_next;
            frame_reg     <= frame_next;
            mode_regs_reg <= mode_regs_next;
        end
    end

    a_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == MODE_CTRL_WR && pending_reg
            && bus_byte[BYTE_W-1 -: 2] == REG_WRITE_CODE
        |=> mode_regs_reg[$past(reg_sel)] == $past(low_byte_reg))
        else $error("mode register not loaded from held byte");

    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == MODE_STAT_RD |=> !frame_reg && !pending_reg)
        else $error("status read left frame flag or latch set");

endmodule

`default_nettype wire

// ===== hdl/vpvi_back.sv =====
`default_nettype none

module vpvi_back #(
    parameter int VRAM_WORDS = vpvi_pkg::VRAM_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  vpvi_pkg::cmd_t                     q_cmd,
    output logic                               pop,
    output logic                               mem_ready,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [vpvi_pkg::BYTE_W-1:0]   read_byte
);

    import vpvi_pkg::*;

    localparam int ADDR_W = $clog2(VRAM_WORDS);

    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_read_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              s1_adv;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    assign mem_ready = !clr_busy_reg;
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop       = q_valid && mem_ready && (!s1_valid_reg || s1_adv);
    assign out_valid = out_valid_reg;
    assign read_byte = out_byte_reg;

    // Memory port: clearing pass first, then queued commands
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = q_cmd.addr[ADDR_W-1:0];
        ram_wdata = q_cmd.data;
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (pop && q_cmd.op == OP_WRITE)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = pop && (q_cmd.op == OP_READ);

    vpvi_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (VRAM_WORDS)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_cmd.addr[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Sweep the memory once after reset
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(VRAM_WORDS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // Advance the access stage and the output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the command in flight and the result
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_read_reg <= (q_cmd.op == OP_READ);
            s1_byte_reg <= (q_cmd.op == OP_CONST) ? q_cmd.data : '0;
        end
        if (s1_adv)
        begin
            out_byte_reg <= s1_read_reg ? ram_rdata : s1_byte_reg;
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !pop && !ram_re)
        else $error("command taken during clearing pass");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_read_reg))
        else $error("access stage lost a stalled command");

endmodule

`default_nettype wire

// ===== hdl/video_port_vram_interface.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_stall  | mode, bus_byte
// output  | out       | out_valid / out_stall| read_byte
//
// One access is taken per cycle while the command queue has room and no clear is running;
// its result byte then passes the queue, the registered read and the output register.
// After reset the memory is swept to zero, one byte a cycle, so in_stall is high
// until the sweep has finished.
// Port state (latch, pointer, mode registers, frame flag) updates at acceptance;
// memory accesses wait in a two-entry queue, and out_stall backs up through it.

module video_port_vram_interface #(
    parameter int VRAM_WORDS = vpvi_pkg::VRAM_WORDS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    mode,
    input  wire logic [vpvi_pkg::BYTE_W-1:0]   bus_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [vpvi_pkg::BYTE_W-1:0]   read_byte
);

    import vpvi_pkg::*;

    logic mem_ready;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_cmd;

    vpvi_front #(
        .VRAM_WORDS (VRAM_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .bus_byte  (bus_byte),
        .mem_ready (mem_ready),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    vpvi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .pop_cmd  (q_cmd)
    );

    vpvi_back #(
        .VRAM_WORDS (VRAM_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .mem_ready (mem_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_byte (read_byte)
    );

endmodule

`default_nettype wire
